### sv/bost_pkg.sv
// Package with shared types, codes, constants and the staged response byte function.
`timescale 1ns / 1ps
package bost_pkg;

  localparam int BlockBytes = 512;
  localparam int BlkShift   = $clog2(BlockBytes);
  localparam int MaxPacket  = 64;

  localparam logic [31:0] CBW_SIG   = 32'h43425355;
  localparam logic [6:0]  WRAP_LEN  = 7'd31;
  localparam logic [6:0]  STAT_LEN  = 7'd13;

  localparam logic [1:0] CMD_OUT       = 2'd0;
  localparam logic [1:0] CMD_IN        = 2'd1;
  localparam logic [1:0] CMD_BOT_RESET = 2'd2;
  localparam logic [1:0] CMD_BUS_RESET = 2'd3;

  localparam logic [2:0] K_ACCEPT = 3'd0;
  localparam logic [2:0] K_STALL  = 3'd1;
  localparam logic [2:0] K_BYTE   = 3'd2;
  localparam logic [2:0] K_READ   = 3'd3;
  localparam logic [2:0] K_WRITE  = 3'd4;
  localparam logic [2:0] K_ZERO   = 3'd5;
  localparam logic [2:0] K_STATUS = 3'd6;

  localparam logic [1:0] SRC_NONE    = 2'd0;
  localparam logic [1:0] SRC_STAGED  = 2'd1;
  localparam logic [1:0] SRC_STORAGE = 2'd2;
  localparam logic [1:0] SRC_ZERO    = 2'd3;

  localparam logic [1:0] STG_SENSE    = 2'd0;
  localparam logic [1:0] STG_INQUIRY  = 2'd1;
  localparam logic [1:0] STG_MODE     = 2'd2;
  localparam logic [1:0] STG_CAPACITY = 2'd3;

  localparam logic [7:0] OP_TUR      = 8'h00;
  localparam logic [7:0] OP_SENSE    = 8'h03;
  localparam logic [7:0] OP_INQUIRY  = 8'h12;
  localparam logic [7:0] OP_MODE     = 8'h1a;
  localparam logic [7:0] OP_STARTSTP = 8'h1b;
  localparam logic [7:0] OP_PREVENT  = 8'h1e;
  localparam logic [7:0] OP_SYNC     = 8'h35;
  localparam logic [7:0] OP_CAPACITY = 8'h25;
  localparam logic [7:0] OP_READ     = 8'h28;
  localparam logic [7:0] OP_WRITE    = 8'h2a;

  localparam logic [1:0] CFG_MEDIUM_PRESENT = 2'd0;
  localparam logic [1:0] CFG_WR_PROT        = 2'd1;
  localparam logic [1:0] CFG_MEDIUM_BLOCKS  = 2'd2;

  localparam logic [7:0] IDENT_TEXT [28] = '{
    8'h69, 8'h72, 8'h69, 8'h73, 8'h20, 8'h20, 8'h20, 8'h20,
    8'h55, 8'h53, 8'h42, 8'h20, 8'h44, 8'h72, 8'h69, 8'h76,
    8'h65, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
    8'h31, 8'h2e, 8'h30, 8'h30
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  length;
    logic        cbw_ok;
    logic [31:0] cbw_tag;
    logic [31:0] cbw_data_length;
    logic        cbw_dir_in;
    logic [7:0]  scsi_opcode;
    logic [31:0] block_address;
    logic [15:0] transfer_blocks;
  } bost_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  byte_count;
    logic [7:0]  data_byte;
    logic [40:0] storage_byte_offset;
    logic [31:0] status_tag;
    logic [31:0] status_residue;
    logic        status_failed;
    logic        last;
  } bost_res_t;

  typedef struct packed {
    logic medium_present;
    logic wr_prot;
    logic [31:0] medium_blocks;
  } bost_cfg_t;

  // Response byte at a given index; word holds sense data, protect flag or last block.
  function automatic logic [7:0] stage_byte(input logic [1:0] sel, input logic [31:0] word,
                                            input logic [5:0] idx);
    logic [7:0] b;
    logic [31:0] blk;
    b = 8'h00;
    blk = 32'(BlockBytes);
    case (sel)
      STG_SENSE: begin
        case (idx)
          6'd0:  b = 8'h70;
          6'd2:  b = word[31:24];
          6'd7:  b = 8'd10;
          6'd12: b = word[23:16];
          6'd13: b = word[15:8];
          default: b = 8'h00;
        endcase
      end
      STG_INQUIRY: begin
        case (idx)
          6'd1: b = 8'h80;
          6'd2: b = 8'h02;
          6'd3: b = 8'h02;
          6'd4: b = 8'd31;
          default: begin
            if (idx >= 6'd8 && idx < 6'd36) b = IDENT_TEXT[5'(idx - 6'd8)];
          end
        endcase
      end
      STG_MODE: begin
        case (idx)
          6'd0: b = 8'h03;
          6'd2: b = word[0] ? 8'h80 : 8'h00;
          default: b = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          6'd0: b = word[31:24];
          6'd1: b = word[23:16];
          6'd2: b = word[15:8];
          6'd3: b = word[7:0];
          6'd4: b = blk[31:24];
          6'd5: b = blk[23:16];
          6'd6: b = blk[15:8];
          6'd7: b = blk[7:0];
          default: b = 8'h00;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

### sv/bost_if.sv
// Channel interfaces for bulk events, results and configuration writes.
`timescale 1ns / 1ps
interface bost_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [6:0]  packet_length;
  logic [31:0] wrapper_sig;
  logic [31:0] cbw_tag;
  logic [31:0] cbw_data_length;
  logic        cbw_dir_in;
  logic [7:0]  scsi_opcode;
  logic [31:0] block_address;
  logic [15:0] transfer_blocks;
  modport source (output valid, command, packet_length, wrapper_sig, cbw_tag,
                  cbw_data_length, cbw_dir_in, scsi_opcode, block_address,
                  transfer_blocks, input ready);
  modport sink (input valid, command, packet_length, wrapper_sig, cbw_tag,
                cbw_data_length, cbw_dir_in, scsi_opcode, block_address,
                transfer_blocks, output ready);
endinterface

interface bost_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [6:0]  byte_count;
  logic [7:0]  data_byte;
  logic [40:0] storage_byte_offset;
  logic [31:0] status_tag;
  logic [31:0] status_residue;
  logic        status_failed;
  logic        last;
  modport source (output valid, kind, byte_count, data_byte, storage_byte_offset,
                  status_tag, status_residue, status_failed, last, input ready);
  modport sink (input valid, kind, byte_count, data_byte, storage_byte_offset,
                status_tag, status_residue, status_failed, last, output ready);
endinterface

interface bost_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/bulk_only_scsi_transport.sv
// Top level of the bulk-only mass storage transport with its SCSI command subset.
//
//   Channel  Dir  Carries
//   in_i     in   bulk events: OUT packet with parsed wrapper, IN request, resets
//   out_o    out  results: accepted, stall, response byte, storage read/write,
//                 zero fill, status wrapper
//   cfg_i    in   register writes: medium present, write protect, medium blocks
//
// An event enters a two-entry queue at its accepting edge; the back end pops it
// when its result register can load. Unless that register stalls, the back end
// then delivers one result per cycle: one or two for most events,
// up to 36 response bytes for an IN during INQUIRY, the longest staged reply.
// Reset clears the phase, the sense data and every saved wrapper field.
// A stalled result register holds the back end; the queue takes events until full.
`timescale 1ns / 1ps
module bulk_only_scsi_transport (
  input  logic  clk_i,
  input  logic  rst_ni,
  bost_in_if.sink     in_i,
  bost_out_if.source  out_o,
  bost_cfg_if.sink    cfg_i
);
  import bost_pkg::*;

  bost_cfg_t  cfg_q;
  logic       q_valid;
  logic       q_pop;
  bost_item_t q_item;

  // Configuration registers take a write in every cycle; the host must write them
  // only while no transaction is in flight, which the block itself does not enforce.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MEDIUM_PRESENT: cfg_q.medium_present <= cfg_i.data[0];
        CFG_WR_PROT:        cfg_q.wr_prot        <= cfg_i.data[0];
        CFG_MEDIUM_BLOCKS:  cfg_q.medium_blocks  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The front end classifies each event and buffers it.
  bost_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_valid_o(q_valid),
    .q_item_o (q_item),
    .q_pop_i  (q_pop)
  );

  // The back end owns the transport phases and produces every result.
  bost_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_valid_i(q_valid),
    .q_item_i (q_item),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );
endmodule

### sv/bost_front.sv
// Front end: accepts bulk events, clamps and checks them, and queues them for the back end.
`timescale 1ns / 1ps
module bost_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  bost_in_if.sink             in_i,
  output logic                q_valid_o,
  output bost_pkg::bost_item_t q_item_o,
  input  logic                q_pop_i
);
  import bost_pkg::*;

  bost_item_t  fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  bost_item_t  item;
  logic        push;

  always_comb begin
    item = '0;
    item.command = in_i.command;
    item.length  = (int'(in_i.packet_length) > MaxPacket) ? 7'(MaxPacket) : in_i.packet_length;
    item.cbw_ok  = (item.length >= WRAP_LEN) && (in_i.wrapper_sig == CBW_SIG);
    item.cbw_tag = in_i.cbw_tag;
    item.cbw_data_length = in_i.cbw_data_length;
    item.cbw_dir_in      = in_i.cbw_dir_in;
    item.scsi_opcode     = in_i.scsi_opcode;
    item.block_address   = in_i.block_address;
    item.transfer_blocks = in_i.transfer_blocks;
  end

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

### sv/bost_back.sv
// Back end: phase tracking, SCSI decode, sense data and result sequencing.
`timescale 1ns / 1ps
module bost_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bost_pkg::bost_cfg_t  cfg_i,
  input  logic                 q_valid_i,
  input  bost_pkg::bost_item_t q_item_i,
  output logic                 q_pop_o,
  bost_out_if.source           out_o
);
  import bost_pkg::*;

  localparam logic [1:0] PH_CMD = 2'd0, PH_DIN = 2'd1, PH_DOUT = 2'd2, PH_STATUS = 2'd3;
  localparam logic [1:0] ST_IDLE = 2'd0, ST_BYTES = 2'd1, ST_ACC = 2'd2;

  logic [1:0]  st_q, st_d, phase_q, phase_d, src_q, src_d, sel_q, sel_d;
  logic [31:0] tag_q, tag_d, hlen_q, hlen_d, resid_q, resid_d, rem_q, rem_d;
  logic [31:0] word_q, word_d;
  logic        fail_q, fail_d;
  logic [40:0] off_q, off_d;
  logic [5:0]  idx_q, idx_d;
  logic [7:0]  sk_q, sk_d, sc_q, sc_d, sq_q, sq_d;
  logic [6:0]  cnt_q, cnt_d, acc_q, acc_d;
  bost_res_t   out_q, out_d, res;
  logic        out_valid_q, out_valid_d, can_load, load;

  // Decode results for a command wrapper at the queue head.
  logic [1:0]  dc_src, dc_sel;
  logic [31:0] dc_rem, dc_word, dc_bytes;
  logic        dc_fail;
  logic [7:0]  dc_sk, dc_sc, dc_sq;
  logic [40:0] dc_off;
  logic [32:0] dc_end;
  logic [6:0]  n;

  always_comb begin
    dc_src = SRC_NONE; dc_rem = '0; dc_fail = 1'b0;
    dc_sk = sk_q; dc_sc = sc_q; dc_sq = sq_q;
    dc_sel = sel_q; dc_word = word_q; dc_off = off_q;
    dc_end = 33'(q_item_i.block_address) + 33'(q_item_i.transfer_blocks);
    dc_bytes = 32'(q_item_i.transfer_blocks) << BlkShift;
    case (q_item_i.scsi_opcode)
      OP_TUR: begin
        if (!cfg_i.medium_present) begin
          dc_fail = 1'b1; dc_sk = 8'h02; dc_sc = 8'h3a; dc_sq = 8'h00;
        end
      end
      OP_SENSE: begin
        dc_sel = STG_SENSE; dc_word = {sk_q, sc_q, sq_q, 8'h00};
        dc_src = SRC_STAGED;
        dc_rem = (q_item_i.cbw_data_length < 32'd18) ? q_item_i.cbw_data_length : 32'd18;
        dc_sk = 8'h00; dc_sc = 8'h00; dc_sq = 8'h00;
      end
      OP_INQUIRY: begin
        dc_sel = STG_INQUIRY; dc_src = SRC_STAGED;
        dc_rem = (q_item_i.cbw_data_length < 32'd36) ? q_item_i.cbw_data_length : 32'd36;
      end
      OP_MODE: begin
        dc_sel = STG_MODE; dc_word = {31'd0, cfg_i.wr_prot}; dc_src = SRC_STAGED;
        dc_rem = (q_item_i.cbw_data_length < 32'd4) ? q_item_i.cbw_data_length : 32'd4;
      end
      OP_STARTSTP, OP_PREVENT, OP_SYNC: begin
      end
      OP_CAPACITY: begin
        if (!cfg_i.medium_present) begin
          dc_fail = 1'b1; dc_sk = 8'h02; dc_sc = 8'h3a; dc_sq = 8'h00;
        end else begin
          dc_sel = STG_CAPACITY; dc_src = SRC_STAGED;
          dc_word = (cfg_i.medium_blocks != 32'd0) ? cfg_i.medium_blocks - 32'd1 : 32'd0;
          dc_rem = (q_item_i.cbw_data_length < 32'd8) ? q_item_i.cbw_data_length : 32'd8;
        end
      end
      OP_READ, OP_WRITE: begin
        if (!cfg_i.medium_present) begin
          dc_fail = 1'b1; dc_sk = 8'h02; dc_sc = 8'h3a; dc_sq = 8'h00;
        end else if (q_item_i.scsi_opcode == OP_WRITE && cfg_i.wr_prot) begin
          dc_fail = 1'b1; dc_sk = 8'h07; dc_sc = 8'h27; dc_sq = 8'h00;
        end else if (dc_end > 33'(cfg_i.medium_blocks)) begin
          dc_fail = 1'b1; dc_sk = 8'h05; dc_sc = 8'h21; dc_sq = 8'h00;
        end else begin
          dc_off = 41'(q_item_i.block_address) << BlkShift;
          dc_src = SRC_STORAGE;
          dc_rem = (q_item_i.cbw_data_length < dc_bytes) ? q_item_i.cbw_data_length : dc_bytes;
        end
      end
      default: begin
        dc_fail = 1'b1; dc_sk = 8'h05; dc_sc = 8'h20; dc_sq = 8'h00;
      end
    endcase
    if (dc_fail && q_item_i.cbw_data_length != 32'd0) begin
      dc_src = SRC_ZERO;
      dc_rem = q_item_i.cbw_data_length;
    end
  end

  assign n = ({25'd0, q_item_i.length} < rem_q) ? q_item_i.length : rem_q[6:0];
  assign can_load = !out_valid_q || out_o.ready;

  always_comb begin
    st_d = st_q; phase_d = phase_q; src_d = src_q; sel_d = sel_q;
    tag_d = tag_q; hlen_d = hlen_q; resid_d = resid_q; rem_d = rem_q; word_d = word_q;
    fail_d = fail_q; off_d = off_q; idx_d = idx_q;
    sk_d = sk_q; sc_d = sc_q; sq_d = sq_q; cnt_d = cnt_q; acc_d = acc_q;
    res = '0; load = 1'b0; q_pop_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i && can_load) begin
          q_pop_o = 1'b1; load = 1'b1; res.last = 1'b1;
          case (q_item_i.command)
            CMD_BOT_RESET, CMD_BUS_RESET: begin
              phase_d = PH_CMD;
              if (q_item_i.command == CMD_BUS_RESET) begin
                sk_d = 8'h00; sc_d = 8'h00; sq_d = 8'h00;
              end
              res.kind = K_ACCEPT;
            end
            CMD_OUT: begin
              if (phase_q == PH_CMD && q_item_i.cbw_ok) begin
                tag_d = q_item_i.cbw_tag; hlen_d = q_item_i.cbw_data_length;
                src_d = dc_src; rem_d = dc_rem; fail_d = dc_fail; idx_d = '0;
                sk_d = dc_sk; sc_d = dc_sc; sq_d = dc_sq;
                sel_d = dc_sel; word_d = dc_word; off_d = dc_off;
                resid_d = q_item_i.cbw_data_length - dc_rem;
                if (dc_rem == 32'd0) phase_d = PH_STATUS;
                else phase_d = q_item_i.cbw_dir_in ? PH_DIN : PH_DOUT;
                res.kind = K_ACCEPT; res.byte_count = WRAP_LEN;
              end else if (phase_q == PH_DOUT) begin
                rem_d = rem_q - 32'(n);
                if (rem_d == 32'd0) phase_d = PH_STATUS;
                if (src_q == SRC_STORAGE && cfg_i.medium_present && n != 7'd0) begin
                  res.kind = K_WRITE; res.byte_count = n; res.storage_byte_offset = off_q;
                  res.last = 1'b0;
                  off_d = off_q + 41'(n);
                  acc_d = q_item_i.length; st_d = ST_ACC;
                end else begin
                  res.kind = K_ACCEPT; res.byte_count = q_item_i.length;
                end
              end else begin
                res.kind = K_STALL;
              end
            end
            default: begin
              if (phase_q == PH_DIN) begin
                rem_d = rem_q - 32'(n);
                if (rem_d == 32'd0) phase_d = PH_STATUS;
                if (n == 7'd0) begin
                  res.kind = K_ACCEPT;
                end else if (src_q == SRC_STAGED) begin
                  res.kind = K_BYTE; res.byte_count = 7'd1;
                  res.data_byte = stage_byte(sel_q, word_q, idx_q);
                  idx_d = idx_q + 6'd1;
                  if (n != 7'd1) begin
                    res.last = 1'b0; cnt_d = n - 7'd1; st_d = ST_BYTES;
                  end
                end else if (src_q == SRC_STORAGE && cfg_i.medium_present) begin
                  res.kind = K_READ; res.byte_count = n; res.storage_byte_offset = off_q;
                  off_d = off_q + 41'(n);
                end else begin
                  res.kind = K_ZERO; res.byte_count = n;
                end
              end else if (phase_q == PH_STATUS) begin
                res.kind = K_STATUS;
                res.byte_count = (q_item_i.length < STAT_LEN) ? q_item_i.length : STAT_LEN;
                res.status_tag = tag_q; res.status_residue = resid_q; res.status_failed = fail_q;
                phase_d = PH_CMD;
              end else begin
                res.kind = K_STALL;
              end
            end
          endcase
        end
      end
      ST_BYTES: begin
        if (can_load) begin
          load = 1'b1;
          res.kind = K_BYTE; res.byte_count = 7'd1;
          res.data_byte = stage_byte(sel_q, word_q, idx_q);
          res.last = (cnt_q == 7'd1);
          idx_d = idx_q + 6'd1;
          cnt_d = cnt_q - 7'd1;
          if (cnt_q == 7'd1) st_d = ST_IDLE;
        end
      end
      ST_ACC: begin
        if (can_load) begin
          load = 1'b1;
          res.kind = K_ACCEPT; res.byte_count = acc_q; res.last = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    out_d = load ? res : out_q;
    out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; phase_q <= PH_CMD; src_q <= SRC_NONE; sel_q <= STG_SENSE;
      tag_q <= '0; hlen_q <= '0; resid_q <= '0; rem_q <= '0; word_q <= '0;
      fail_q <= 1'b0; off_q <= '0; idx_q <= '0;
      sk_q <= '0; sc_q <= '0; sq_q <= '0; cnt_q <= '0; acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d; phase_q <= phase_d; src_q <= src_d; sel_q <= sel_d;
      tag_q <= tag_d; hlen_q <= hlen_d; resid_q <= resid_d; rem_q <= rem_d; word_q <= word_d;
      fail_q <= fail_d; off_q <= off_d; idx_q <= idx_d;
      sk_q <= sk_d; sc_q <= sc_d; sq_q <= sq_d; cnt_q <= cnt_d; acc_q <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.kind                = out_q.kind;
  assign out_o.byte_count          = out_q.byte_count;
  assign out_o.data_byte           = out_q.data_byte;
  assign out_o.storage_byte_offset = out_q.storage_byte_offset;
  assign out_o.status_tag          = out_q.status_tag;
  assign out_o.status_residue      = out_q.status_residue;
  assign out_o.status_failed       = out_q.status_failed;
  assign out_o.last                = out_q.last;
endmodule

### sv/bost_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
module bost_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid,
  input logic        ready,
  input logic [2:0]  kind,
  input logic [6:0]  byte_count,
  input logic [31:0] status_tag,
  input logic        last
);
  import bost_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && !ready |=> valid && $stable(kind) && $stable(byte_count))
    else $error("result changed while stalled");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && (kind == K_STALL || kind == K_STATUS || kind == K_READ || kind == K_ZERO) |-> last)
    else $error("single result without last");

  a_status_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && kind == K_STATUS |-> byte_count <= STAT_LEN)
    else $error("status longer than wrapper");

  a_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && kind == K_BYTE |-> byte_count == 7'd1)
    else $error("response byte count not one");

  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid && kind != K_STATUS |-> status_tag == 32'd0)
    else $error("tag on a non-status result");
endmodule

bind bulk_only_scsi_transport bost_checker u_bost_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid     (out_o.valid),
  .ready     (out_o.ready),
  .kind      (out_o.kind),
  .byte_count(out_o.byte_count),
  .status_tag(out_o.status_tag),
  .last      (out_o.last)
);
